// File: rtl/assert_macros.svh
// assertion macros for the codec rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is held off while reset is active
`define BCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check that also covers the reset cycles
`define BCC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/bcc_pkg.sv
// package: types, constants and lookup functions of the base32 codec
package bcc_pkg;

    localparam int unsigned GROUP_W   = 40;
    localparam int unsigned JOB_DEPTH = 2;
    localparam int unsigned JOB_PTR_W = 1;
    localparam int unsigned JOB_CNT_W = 2;

    localparam logic       MODE_ENC = 1'b0;
    localparam logic       MODE_DEC = 1'b1;
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_LEN  = 2'd1,
        ST_PAD  = 2'd2,
        ST_CHAR = 2'd3
    } t_status;

    // one unit of output work: a finished group and how to emit it
    typedef struct packed {
        logic               mode;
        logic [GROUP_W-1:0] bits;
        logic [3:0]         nsym;
        logic [3:0]         ntot;
        logic               last;
        t_status            status;
    } t_job;

    // symbol value of a character, valid flag in the top bit
    function automatic logic [5:0] sym_lookup(input logic [7:0] c);
        logic [5:0] r;
        r = 6'd0;
        case (c) inside
            [8'h41:8'h5A]: r = {1'b1, 5'(c - 8'h41)};
            8'h31:         r = {1'b1, 5'd26};
            8'h32:         r = {1'b1, 5'd27};
            8'h35:         r = {1'b1, 5'd28};
            8'h36:         r = {1'b1, 5'd29};
            8'h38:         r = {1'b1, 5'd30};
            8'h39:         r = {1'b1, 5'd31};
            default:       r = 6'd0;
        endcase
        return r;
    endfunction

    // character of a symbol value
    function automatic logic [7:0] enc_char(input logic [4:0] v);
        logic [7:0] r;
        case (v) inside
            [5'd0:5'd25]: r = 8'h41 + {3'd0, v};
            5'd26:        r = 8'h31;
            5'd27:        r = 8'h32;
            5'd28:        r = 8'h35;
            5'd29:        r = 8'h36;
            5'd30:        r = 8'h38;
            5'd31:        r = 8'h39;
            default:      r = 8'h41;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/base32_stream_codec_unit.sv
// Streaming base32 codec (alphabet A-Z then 1,2,5,6,8,9, '=' padding).
// Input side is a queue write port: an item (one byte or one character plus
// a last marker) is taken when push is high and full is low. Result side is a
// queue read port: the oldest result sits on the o_ ports while empty is low
// and leaves on pop. The direction register is written over its own
// valid/ready channel (always ready); the user must write it only while the
// block is idle, which the block does not enforce. A write also drops any
// partial group. direction 0 encodes, 1 decodes. A group that completes on
// an item goes into the job queue, then the back end, then the output
// register. The back end emits one result per cycle while the receiver
// pops, so it paces encoding, and decoding takes one character per cycle. The
// job queue between group builder and result expander holds two groups; full
// rises when it is full. A stalled receiver holds the output register and
// back end, the queue fills, then full holds off the sender; nothing is lost.
// Reset (synchronous, active low) selects encode, clears all group state and
// empties the queue and output register. A malformed decode message ends in
// one result with data 0, last set and a nonzero status.
`include "assert_macros.svh"

module base32_stream_codec_unit import bcc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_in,
    input  logic       i_last_in,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_data_out,
    output logic       o_last_out,
    output logic [1:0] o_status,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);

    logic    accept;
    logic    cfg_we;
    logic    dir;
    logic    job_push;
    t_job    job_in;
    logic    job_full;
    logic    job_nonempty;
    t_job    job_out;
    logic    job_pop;
    t_status out_status;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign full        = job_full;
    assign accept      = push && !job_full;
    assign o_status    = out_status;

    // group builder
    bcc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_data     (i_data_in),
        .i_last     (i_last_in),
        .o_dir      (dir),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    // job queue
    bcc_job_fifo u_job_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (job_push),
        .i_job      (job_in),
        .i_pop      (job_pop),
        .o_full     (job_full),
        .o_nonempty (job_nonempty),
        .o_job      (job_out)
    );

    // result expander
    bcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_nonempty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_data      (o_data_out),
        .o_last      (o_last_out),
        .o_status    (out_status)
    );

    // checks
    `BCC_ASSERT(a_flag_shape, (!empty && o_status != ST_OK) |-> (o_data_out == 8'd0 && o_last_out), "flagged result must be zero data and last")
    `BCC_ASSERT(a_enc_ok, (!empty && dir == MODE_ENC) |-> (o_status == ST_OK), "encode result with nonzero status")
    `BCC_ASSERT(a_no_overflow, job_push |-> !job_full, "job pushed into full queue")
    `BCC_ASSERT_RST(a_reset_empty, !i_rst_n |=> empty, "results visible right after reset")

endmodule

// File: rtl/bcc_front.sv
// front end: takes items, builds groups, classifies them into jobs
module bcc_front import bcc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_accept,
    input  logic [7:0] i_data,
    input  logic       i_last,
    output logic       o_dir,
    output logic       o_job_push,
    output t_job       o_job
);

    logic               r_dir,  n_dir;
    logic [GROUP_W-1:0] r_bits, n_bits;
    logic [2:0]         r_cnt,  n_cnt;
    logic [3:0]         r_pad,  n_pad;
    logic               r_err,  n_err;

    logic [GROUP_W-1:0] enc_bits;
    logic [GROUP_W-1:0] enc_aligned;
    logic [2:0]         enc_cnt;
    logic [3:0]         enc_nsym;
    logic [5:0]         sym;
    logic               is_pad;
    logic [4:0]         dec_val;
    logic [GROUP_W-1:0] dec_bits;
    logic [2:0]         dec_cnt;
    logic [3:0]         pad_next;
    logic               err_next;
    logic               grp_err;
    t_status            fin_status;
    logic [3:0]         fin_nbytes;

    // encode path: shift the byte in, left-align a short group
    assign enc_bits = {r_bits[GROUP_W-9:0], i_data};
    assign enc_cnt  = r_cnt + 3'd1;

    always_comb begin
        case (enc_cnt)
            3'd1:    begin enc_aligned = enc_bits << 32; enc_nsym = 4'd2; end
            3'd2:    begin enc_aligned = enc_bits << 24; enc_nsym = 4'd4; end
            3'd3:    begin enc_aligned = enc_bits << 16; enc_nsym = 4'd5; end
            3'd4:    begin enc_aligned = enc_bits << 8;  enc_nsym = 4'd7; end
            default: begin enc_aligned = enc_bits;       enc_nsym = 4'd8; end
        endcase
    end

    // decode path: symbol value, pad tracking, error tracking
    assign sym      = sym_lookup(i_data);
    assign is_pad   = (i_data == PAD_CHAR);
    assign dec_val  = is_pad ? 5'd0 : sym[4:0];
    assign dec_bits = {r_bits[GROUP_W-6:0], dec_val};
    assign dec_cnt  = r_cnt + 3'd1;
    assign pad_next = !is_pad ? 4'd0 : ((r_pad == 4'd15) ? 4'd15 : r_pad + 4'd1);
    assign err_next = r_err | (!is_pad && (!sym[5] || (r_pad != 4'd0)));
    assign grp_err  = err_next | (pad_next != 4'd0);

    // final group checks
    always_comb begin
        fin_nbytes = 4'd0;
        fin_status = ST_OK;
        if (dec_cnt != 3'd0) begin
            fin_status = ST_LEN;
        end else begin
            case (pad_next)
                4'd0:    fin_nbytes = 4'd5;
                4'd1:    fin_nbytes = 4'd4;
                4'd3:    fin_nbytes = 4'd3;
                4'd4:    fin_nbytes = 4'd2;
                4'd6:    fin_nbytes = 4'd1;
                default: fin_status = ST_PAD;
            endcase
            if (fin_status == ST_OK && err_next) begin
                fin_status = ST_CHAR;
            end
        end
    end

    // group state update and job generation
    always_comb begin
        n_dir      = r_dir;
        n_bits     = r_bits;
        n_cnt      = r_cnt;
        n_pad      = r_pad;
        n_err      = r_err;
        o_job_push = 1'b0;
        o_job      = '0;
        if (i_cfg_we) begin
            n_dir  = i_cfg_data;
            n_bits = '0;
            n_cnt  = 3'd0;
            n_pad  = 4'd0;
            n_err  = 1'b0;
        end else if (i_accept) begin
            if (r_dir == MODE_ENC) begin
                n_bits = enc_bits;
                n_cnt  = enc_cnt;
                if (enc_cnt == 3'd5 || i_last) begin
                    o_job_push  = 1'b1;
                    o_job.mode  = MODE_ENC;
                    o_job.bits  = enc_aligned;
                    o_job.nsym  = enc_nsym;
                    o_job.ntot  = 4'd8;
                    o_job.last  = i_last;
                    o_job.status = ST_OK;
                    n_bits = '0;
                    n_cnt  = 3'd0;
                end
            end else if (!i_last) begin
                n_bits = dec_bits;
                n_cnt  = dec_cnt;
                n_pad  = pad_next;
                n_err  = err_next;
                if (dec_cnt == 3'd0) begin
                    n_err  = grp_err;
                    n_bits = '0;
                    n_pad  = 4'd0;
                    if (!grp_err) begin
                        o_job_push   = 1'b1;
                        o_job.mode   = MODE_DEC;
                        o_job.bits   = dec_bits;
                        o_job.ntot   = 4'd5;
                        o_job.status = ST_OK;
                    end
                end
            end else begin
                o_job_push   = 1'b1;
                o_job.mode   = MODE_DEC;
                o_job.bits   = dec_bits;
                o_job.ntot   = (fin_status == ST_OK) ? fin_nbytes : 4'd1;
                o_job.last   = 1'b1;
                o_job.status = fin_status;
                n_bits = '0;
                n_cnt  = 3'd0;
                n_pad  = 4'd0;
                n_err  = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= MODE_ENC;
            r_bits <= '0;
            r_cnt  <= 3'd0;
            r_pad  <= 4'd0;
            r_err  <= 1'b0;
        end else begin
            r_dir  <= n_dir;
            r_bits <= n_bits;
            r_cnt  <= n_cnt;
            r_pad  <= n_pad;
            r_err  <= n_err;
        end
    end

    assign o_dir = r_dir;

endmodule

// File: rtl/bcc_job_fifo.sv
// two-entry job queue between front and back end
module bcc_job_fifo import bcc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_nonempty,
    output t_job o_job
);

    t_job                 r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [JOB_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [JOB_CNT_W-1:0] r_count,  n_count;

    assign o_full     = (r_count == JOB_CNT_W'(JOB_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_job      = r_mem[r_rd_ptr];

    // pointer and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr + (i_push ? JOB_PTR_W'(1) : '0);
        n_rd_ptr = r_rd_ptr + (i_pop ? JOB_PTR_W'(1) : '0);
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + JOB_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - JOB_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: rtl/bcc_back.sv
// back end: expands jobs, one result per cycle unless held, into an output register
module bcc_back import bcc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_job_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_data,
    output logic       o_last,
    output t_status    o_status
);

    logic               r_busy,   n_busy;
    logic               r_mode,   n_mode;
    logic [GROUP_W-1:0] r_bits,   n_bits;
    logic [3:0]         r_sym,    n_sym;
    logic [3:0]         r_left,   n_left;
    logic               r_jlast,  n_jlast;
    t_status            r_jstat,  n_jstat;

    logic               r_ov,     n_ov;
    logic [7:0]         r_od,     n_od;
    logic               r_ol,     n_ol;
    t_status            r_os,     n_os;

    logic       out_free;
    logic       emit;
    logic       finish;
    logic       load;
    logic [7:0] cur_data;

    assign out_free  = !r_ov || i_pop;
    assign emit      = r_busy && out_free;
    assign finish    = emit && (r_left == 4'd1);
    assign load      = i_job_valid && (!r_busy || finish);
    assign o_job_pop = load;

    // data of the current result
    always_comb begin
        if (r_jstat != ST_OK) begin
            cur_data = 8'd0;
        end else if (r_mode == MODE_ENC) begin
            cur_data = (r_sym != 4'd0) ? enc_char(r_bits[GROUP_W-1 -: 5]) : PAD_CHAR;
        end else begin
            cur_data = r_bits[GROUP_W-1 -: 8];
        end
    end

    // job walk and output register
    always_comb begin
        n_busy  = r_busy;
        n_mode  = r_mode;
        n_bits  = r_bits;
        n_sym   = r_sym;
        n_left  = r_left;
        n_jlast = r_jlast;
        n_jstat = r_jstat;
        n_ov    = r_ov;
        n_od    = r_od;
        n_ol    = r_ol;
        n_os    = r_os;
        if (emit) begin
            n_ov   = 1'b1;
            n_od   = cur_data;
            n_ol   = r_jlast && (r_left == 4'd1);
            n_os   = r_jstat;
            n_bits = (r_mode == MODE_ENC) ? (r_bits << 5) : (r_bits << 8);
            n_sym  = (r_sym != 4'd0) ? r_sym - 4'd1 : 4'd0;
            n_left = r_left - 4'd1;
            if (finish) begin
                n_busy = 1'b0;
            end
        end else if (i_pop) begin
            n_ov = 1'b0;
        end
        if (load) begin
            n_busy  = 1'b1;
            n_mode  = i_job.mode;
            n_bits  = i_job.bits;
            n_sym   = i_job.nsym;
            n_left  = i_job.ntot;
            n_jlast = i_job.last;
            n_jstat = i_job.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_bits  <= n_bits;
        r_sym   <= n_sym;
        r_left  <= n_left;
        r_jlast <= n_jlast;
        r_jstat <= n_jstat;
        r_od    <= n_od;
        r_ol    <= n_ol;
        r_os    <= n_os;
    end

    assign o_empty  = !r_ov;
    assign o_data   = r_od;
    assign o_last   = r_ol;
    assign o_status = r_os;

endmodule

// File: sim/base32_stream_codec_unit_mon.sv
// result monitor for the base32 codec unit: predicts each item's results and compares them
`timescale 1ns / 1ps

module base32_stream_codec_unit_mon
    import bcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_data_in,
    input  logic       i_last_in,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [7:0] i_data_out,
    input  logic       i_last_out,
    input  logic [1:0] i_status,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic       i_cfg_data,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_items,
    output int         o_results,
    output int         o_flagged
);

    localparam logic [8*32-1:0] ALPHABET     = "ABCDEFGHIJKLMNOPQRSTUVWXYZ125689";
    localparam int              REPORT_LINES = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_status    status;
    } t_codec_result;

    // results still owed by the block, oldest first
    t_codec_result codec_result_q[$];

    // predicted codec state
    logic        dir_mode = MODE_ENC;
    logic [39:0] grp_bits = '0;
    logic [2:0]  grp_cnt  = '0;
    logic [3:0]  pad_cnt  = '0;
    logic        char_err = 1'b0;

    int fail_count    = 0;
    int item_count    = 0;
    int result_count  = 0;
    int flagged_count = 0;

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= REPORT_LINES) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function automatic logic [7:0] symbol_char(input logic [4:0] v);
        return ALPHABET[8 * (31 - int'(v)) +: 8];
    endfunction

    // symbol value of a character, -1 when it is not in the alphabet
    function automatic int symbol_value(input logic [7:0] c);
        int k;
        for (k = 0; k < 32; k++) begin
            if (ALPHABET[8 * (31 - k) +: 8] == c) begin
                return k;
            end
        end
        return -1;
    endfunction

    task automatic clear_group();
        grp_bits = '0;
        grp_cnt  = '0;
        pad_cnt  = '0;
        char_err = 1'b0;
    endtask

    task automatic add_result(input logic [7:0] d, input logic l, input t_status s);
        t_codec_result r;
        r.data   = d;
        r.last   = l;
        r.status = s;
        codec_result_q.push_back(r);
    endtask

    // encode: a full group or a final short group gives eight characters
    task automatic encode_byte(input logic [7:0] b, input logic l);
        logic [39:0] aligned;
        int          nchar;
        int          k;
        grp_bits = {grp_bits[31:0], b};
        grp_cnt  = grp_cnt + 3'd1;
        if (grp_cnt == 3'd5 || l) begin
            aligned = grp_bits << (8 * (5 - int'(grp_cnt)));
            case (grp_cnt)
                3'd1: nchar = 2;
                3'd2: nchar = 4;
                3'd3: nchar = 5;
                3'd4: nchar = 7;
                default: nchar = 8;
            endcase
            for (k = 0; k < 8; k++) begin
                add_result((k < nchar) ? symbol_char(aligned[39 - 5 * k -: 5]) : PAD_CHAR,
                           l && k == 7, ST_OK);
            end
            clear_group();
        end
    endtask

    // decode: eight characters give five bytes, the final group may be padded
    task automatic decode_char(input logic [7:0] c, input logic l);
        int      v;
        int      nbytes;
        int      k;
        t_status st;
        v = symbol_value(c);
        if (c == PAD_CHAR) begin
            v = 0;
            if (pad_cnt != 4'd15) begin
                pad_cnt = pad_cnt + 4'd1;
            end
        end else begin
            // unknown character, or data following a pad
            if (v < 0 || pad_cnt != 4'd0) begin
                char_err = 1'b1;
            end
            if (v < 0) begin
                v = 0;
            end
            pad_cnt = 4'd0;
        end
        grp_bits = {grp_bits[34:0], v[4:0]};
        grp_cnt  = grp_cnt + 3'd1;
        if (!l) begin
            if (grp_cnt == 3'd0) begin
                // pads are only legal in the final group
                if (pad_cnt != 4'd0) begin
                    char_err = 1'b1;
                end
                if (!char_err) begin
                    for (k = 0; k < 5; k++) begin
                        add_result(grp_bits[39 - 8 * k -: 8], 1'b0, ST_OK);
                    end
                end
                grp_bits = '0;
                pad_cnt  = '0;
            end
        end else begin
            st     = ST_OK;
            nbytes = 0;
            if (grp_cnt != 3'd0) begin
                st = ST_LEN;
            end else begin
                case (pad_cnt)
                    4'd0: nbytes = 5;
                    4'd1: nbytes = 4;
                    4'd3: nbytes = 3;
                    4'd4: nbytes = 2;
                    4'd6: nbytes = 1;
                    default: st = ST_PAD;
                endcase
                if (st == ST_OK && char_err) begin
                    st = ST_CHAR;
                end
            end
            if (st != ST_OK) begin
                add_result(8'h00, 1'b1, st);
            end else begin
                for (k = 0; k < nbytes; k++) begin
                    add_result(grp_bits[39 - 8 * k -: 8], k == nbytes - 1, ST_OK);
                end
            end
            clear_group();
        end
    endtask

    always @(posedge i_clk) begin : watch_edge
        t_codec_result want;
        if (!i_rst_n) begin
            dir_mode = MODE_ENC;
            clear_group();
            codec_result_q.delete();
        end else begin
            // outgoing result against the oldest prediction
            if (i_pop && !i_empty) begin
                result_count++;
                if (i_status != ST_OK) begin
                    flagged_count++;
                end
                if (codec_result_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result data %02h last %0b status %0d",
                                              i_data_out, i_last_out, i_status));
                end else begin
                    want = codec_result_q.pop_front();
                    if (i_data_out !== want.data) begin
                        report_mismatch($sformatf("data %02h, predicted %02h",
                                                  i_data_out, want.data));
                    end
                    if (i_last_out !== want.last) begin
                        report_mismatch($sformatf("last %0b, predicted %0b",
                                                  i_last_out, want.last));
                    end
                    if (i_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  i_status, want.status));
                    end
                end
            end
            // direction write drops any partial message
            if (i_cfg_valid && i_cfg_ready) begin
                dir_mode = i_cfg_data;
                clear_group();
            end
            // incoming item
            if (i_push && !i_full) begin
                item_count++;
                if (dir_mode == MODE_ENC) begin
                    encode_byte(i_data_in, i_last_in);
                end else begin
                    decode_char(i_data_in, i_last_in);
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= codec_result_q.size();
        o_items      <= item_count;
        o_results    <= result_count;
        o_flagged    <= flagged_count;
    end

endmodule

// File: sim/base32_stream_codec_unit_tb.sv
// testbench top for the base32 codec unit: stimulus, idling, watchdog and verdict
`timescale 1ns / 1ps

module base32_stream_codec_unit_tb;
    import bcc_pkg::*;

    localparam int              RESET_CYCLES  = 7;
    localparam int              SETTLE_CYCLES = 12;
    localparam int              HOLD_CYCLES   = 200;
    localparam int              STALL_LIMIT   = 2000;
    localparam logic [8*32-1:0] ALPHABET      = "ABCDEFGHIJKLMNOPQRSTUVWXYZ125689";

    typedef enum int {
        MSG_CLEAN,
        MSG_BAD_PADS,
        MSG_BAD_LEN,
        MSG_BAD_CHAR,
        MSG_CHAR_AFTER_PAD,
        MSG_EARLY_PAD
    } t_msg_kind;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_data_in;
    logic       i_last_in;
    logic       empty;
    logic       pop;
    logic [7:0] o_data_out;
    logic       o_last_out;
    logic [1:0] o_status;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_data;

    int fail_count;
    int pending;
    int items_seen;
    int results_seen;
    int flagged_seen;

    logic [7:0] msg_q[$];
    int         items_sent    = 0;
    int         idle_cycles   = 0;
    int         full_cycles   = 0;
    bit         src_idle_en   = 1'b1;
    bit         sink_idle_en  = 1'b1;
    bit         sink_hold_req = 1'b0;

    base32_stream_codec_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_data_in   (i_data_in),
        .i_last_in   (i_last_in),
        .empty       (empty),
        .pop         (pop),
        .o_data_out  (o_data_out),
        .o_last_out  (o_last_out),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    base32_stream_codec_unit_mon u_codec_mon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_data_in    (i_data_in),
        .i_last_in    (i_last_in),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_data_out   (o_data_out),
        .i_last_out   (o_last_out),
        .i_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_items      (items_seen),
        .o_results    (results_seen),
        .o_flagged    (flagged_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side: random pop gaps, plus one long hold on request
    initial begin : result_sink
        int gap_left;
        gap_left = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                gap_left      = HOLD_CYCLES;
            end else if (gap_left == 0 && sink_idle_en && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(1, 5);
            end
            if (gap_left > 0) begin
                pop <= 1'b0;
                gap_left--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no item moving either way
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (push && full) begin
            full_cycles <= full_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // one item on the input queue port, with an optional gap before it
    task automatic send_item(input logic [7:0] d, input logic l);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_data_in <= d;
        i_last_in <= l;
        push      <= 1'b1;
        do @(posedge i_clk); while (full);
        items_sent++;
    endtask

    task automatic send_message();
        int k;
        for (k = 0; k < msg_q.size(); k++) begin
            send_item(msg_q[k], k == msg_q.size() - 1);
        end
    endtask

    // stop sending and wait out every owed result plus the pipeline depth
    task automatic drain_block();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_direction(input logic dir);
        i_cfg_data  <= dir;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_symbol();
        return ALPHABET[8 * $urandom_range(0, 31) +: 8];
    endfunction

    // any byte that is neither an alphabet character nor a pad
    function automatic logic [7:0] random_noise();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while ((c >= "A" && c <= "Z") || c == "1" || c == "2" || c == "5" || c == "6" ||
               c == "8" || c == "9" || c == PAD_CHAR) begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic int clean_pad_count();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 1;
            2: return 3;
            3: return 4;
            default: return 6;
        endcase
    endfunction

    function automatic int bad_pad_count();
        case ($urandom_range(0, 3))
            0: return 2;
            1: return 5;
            2: return 7;
            default: return 8;
        endcase
    endfunction

    function automatic t_msg_kind pick_decode_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return MSG_CLEAN;
        if (r < 68) return MSG_BAD_PADS;
        if (r < 76) return MSG_BAD_LEN;
        if (r < 84) return MSG_BAD_CHAR;
        if (r < 92) return MSG_CHAR_AFTER_PAD;
        return MSG_EARLY_PAD;
    endfunction

    task automatic build_encode_message();
        int len;
        int k;
        msg_q.delete();
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
        for (k = 0; k < len; k++) begin
            msg_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // well-formed groups with random content, then one fault by kind, none when clean
    task automatic build_decode_message(input t_msg_kind kind);
        int groups;
        int npad;
        int total;
        int k;
        msg_q.delete();
        groups = (kind == MSG_EARLY_PAD) ? $urandom_range(2, 3) : $urandom_range(1, 3);
        case (kind)
            MSG_BAD_PADS:       npad = bad_pad_count();
            MSG_CHAR_AFTER_PAD: npad = $urandom_range(2, 7);
            default:            npad = clean_pad_count();
        endcase
        total = groups * 8;
        for (k = 0; k < total; k++) begin
            msg_q.push_back((k >= total - npad) ? PAD_CHAR : random_symbol());
        end
        case (kind)
            MSG_BAD_LEN: begin
                if ($urandom_range(0, 1) == 0) begin
                    repeat ($urandom_range(1, 7)) msg_q.push_back(random_symbol());
                end else begin
                    repeat ($urandom_range(1, 7)) msg_q.delete(msg_q.size() - 1);
                end
            end
            MSG_BAD_CHAR:       msg_q[$urandom_range(0, total - npad - 1)] = random_noise();
            MSG_CHAR_AFTER_PAD: msg_q[total - 1] = random_symbol();
            MSG_EARLY_PAD:      msg_q[$urandom_range(0, total - 9)] = PAD_CHAR;
            default: ;
        endcase
    endtask

    initial begin : stimulus
        int target;
        int k;
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_data_in   <= 8'h00;
        i_last_in   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= MODE_ENC;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed encode: one-byte message, then a full group and a one-byte tail
        write_direction(MODE_ENC);
        msg_q = '{8'hFF};
        send_message();
        msg_q = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80};
        send_message();
        drain_block();

        // directed decode: four pads, short message of noise, a group of pads only
        write_direction(MODE_DEC);
        msg_q = '{"A", "9", "Z", "1", PAD_CHAR, PAD_CHAR, PAD_CHAR, PAD_CHAR};
        send_message();
        msg_q = '{8'h00, 8'hFF};
        send_message();
        msg_q.delete();
        repeat (8) msg_q.push_back(PAD_CHAR);
        send_message();
        drain_block();

        // random encode messages, idling on both sides
        write_direction(MODE_ENC);
        target = items_sent + 60;
        while (items_sent < target) begin
            build_encode_message();
            send_message();
        end
        drain_block();

        // random decode messages, mostly well formed
        write_direction(MODE_DEC);
        target = items_sent + 70;
        while (items_sent < target) begin
            build_decode_message(pick_decode_kind());
            send_message();
        end
        drain_block();

        // partial message left behind, then dropped by the direction write
        msg_q = '{"Q", "8", PAD_CHAR};
        for (k = 0; k < msg_q.size(); k++) begin
            send_item(msg_q[k], 1'b0);
        end
        drain_block();
        write_direction(MODE_ENC);

        // long receiver hold while bytes keep coming, so full must rise
        src_idle_en   = 1'b0;
        sink_hold_req = 1'b1;
        target = items_sent + 30;
        while (items_sent < target) begin
            build_encode_message();
            send_message();
        end
        drain_block();

        // final stretch with no idling at all
        write_direction(MODE_DEC);
        sink_idle_en = 1'b0;
        target = items_sent + 40;
        while (items_sent < target) begin
            build_decode_message(pick_decode_kind());
            send_message();
        end
        drain_block();

        $display("run: %0d items in, %0d results out, %0d flagged decode ends, both directions",
                 items_seen, results_seen, flagged_seen);
        $display("run: input held off by full for %0d cycles, partial message dropped on write",
                 full_cycles);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
